// ===== rtl/imw_pkg.sv =====
// ---------------------------------------------------------------------------
// imw_pkg
// Shared types and constants of the wildcard name matcher.
// ---------------------------------------------------------------------------
package imw_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int WORD_COUNT = 6;
    localparam int LEN_W      = 6;
    localparam int CHAR_W     = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_WORD_LAST = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_HIER_DELIM        = 3'd7;

    localparam logic [CHAR_W-1:0] STAR_CHAR    = 8'h2A;
    localparam logic [CHAR_W-1:0] PERCENT_CHAR = 8'h25;
    localparam logic [CHAR_W-1:0] DELIM_RESET  = 8'h2F;

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    typedef struct packed {
        logic has;
        logic last;
    } imw_flags_t;

endpackage

// ===== rtl/imw_queue.sv =====
// ---------------------------------------------------------------------------
// imw_queue
// Two-entry queue that decouples the classify front from the nfa back.
// ---------------------------------------------------------------------------
module imw_queue #(
    parameter int WIDTH = 98
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             q_full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             q_empty
);

    logic [WIDTH-1:0]                  mem_reg [imw_pkg::QUEUE_DEPTH];
    logic [imw_pkg::QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [imw_pkg::QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [imw_pkg::QUEUE_CNT_W-1:0]   count_reg;
    logic [imw_pkg::QUEUE_CNT_W-1:0]   count_next;
    logic                              do_wr;
    logic                              do_rd;

    assign q_full  = (count_reg == imw_pkg::QUEUE_CNT_W'(imw_pkg::QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= imw_pkg::QUEUE_CNT_W'(imw_pkg::QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_write_counts: assert property (@(posedge clk) disable iff (!rst_n)
        do_wr && !do_rd |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue write not counted");

    a_read_counts: assert property (@(posedge clk) disable iff (!rst_n)
        do_rd && !do_wr |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue read not counted");

endmodule

// ===== rtl/imw_front.sv =====
// ---------------------------------------------------------------------------
// imw_front
// Configuration registers and byte classification: turns each name byte
// into per-position stay and step masks for the nfa.
// ---------------------------------------------------------------------------
module imw_front #(
    parameter int MAX_CHARS = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [imw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               push,
    input  logic [imw_pkg::CHAR_W-1:0]         name_byte,
    input  logic                               has_byte,
    input  logic                               end_of_name,
    input  logic                               q_full,
    output logic                               full,
    output logic                               q_wr,
    output logic [2*MAX_CHARS+1:0]             q_wdata,
    output logic [MAX_CHARS-1:0]               prop_mask,
    output logic [MAX_CHARS:0]                 end_mask
);

    localparam logic [imw_pkg::LEN_W-1:0] LEN_CAP = imw_pkg::LEN_W'(MAX_CHARS);
    localparam int FLAT_W = imw_pkg::WORD_COUNT * imw_pkg::CFG_DATA_W;

    logic [imw_pkg::CFG_DATA_W-1:0] pattern_word_reg [imw_pkg::WORD_COUNT];
    logic [imw_pkg::LEN_W-1:0]      pattern_length_reg;
    logic [imw_pkg::CHAR_W-1:0]     delim_reg;
    logic [FLAT_W-1:0]              pattern_flat;
    logic [imw_pkg::LEN_W-1:0]      used_len;
    logic [MAX_CHARS-1:0]           stay;
    logic [MAX_CHARS-1:0]           step;
    imw_pkg::imw_flags_t            flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < imw_pkg::WORD_COUNT; k++)
            begin
                pattern_word_reg[k] <= '0;
            end
            pattern_length_reg <= '0;
            delim_reg          <= imw_pkg::DELIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                imw_pkg::CFG_PATTERN_LENGTH:
                begin
                    pattern_length_reg <= cfg_wdata[imw_pkg::LEN_W-1:0];
                end
                imw_pkg::CFG_HIER_DELIM:
                begin
                    delim_reg <= cfg_wdata[imw_pkg::CHAR_W-1:0];
                end
                default:
                begin
                    if (cfg_index <= imw_pkg::CFG_PATTERN_WORD_LAST)
                    begin
                        pattern_word_reg[cfg_index] <= cfg_wdata;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        for (int k = 0; k < imw_pkg::WORD_COUNT; k++)
        begin
            pattern_flat[k*imw_pkg::CFG_DATA_W +: imw_pkg::CFG_DATA_W] = pattern_word_reg[k];
        end
    end

    // lengths above the position count are clamped
    assign used_len = (pattern_length_reg > LEN_CAP) ? LEN_CAP : pattern_length_reg;

    always_comb
    begin
        logic [imw_pkg::CHAR_W-1:0] pc;
        logic                       in_use;
        logic                       is_star;
        logic                       is_pct;
        pc      = '0;
        in_use  = 1'b0;
        is_star = 1'b0;
        is_pct  = 1'b0;
        for (int i = 0; i < MAX_CHARS; i++)
        begin
            pc      = pattern_flat[i*imw_pkg::CHAR_W +: imw_pkg::CHAR_W];
            in_use  = (imw_pkg::LEN_W'(i) < used_len);
            is_star = (pc == imw_pkg::STAR_CHAR);
            is_pct  = (pc == imw_pkg::PERCENT_CHAR);
            // star keeps its position, percent keeps it unless the byte is the delimiter
            stay[i] = in_use && (is_star || (is_pct && (name_byte != delim_reg)));
            step[i] = in_use && !is_star && !is_pct && (pc == name_byte);
            prop_mask[i] = in_use && (is_star || is_pct);
        end
        for (int k = 0; k <= MAX_CHARS; k++)
        begin
            end_mask[k] = (imw_pkg::LEN_W'(k) == used_len);
        end
    end

    assign flags.has  = has_byte;
    assign flags.last = end_of_name;
    assign full       = q_full;
    assign q_wr       = push && !q_full;
    assign q_wdata    = {stay, step, flags};

endmodule

// ===== rtl/imw_back.sv =====
// ---------------------------------------------------------------------------
// imw_back
// Bit-parallel nfa over pattern positions with wildcard closure, plus the
// result register.
// ---------------------------------------------------------------------------
module imw_back #(
    parameter int MAX_CHARS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  logic [MAX_CHARS-1:0]  stay,
    input  logic [MAX_CHARS-1:0]  step,
    input  imw_pkg::imw_flags_t   flags,
    input  logic [MAX_CHARS-1:0]  prop_mask,
    input  logic [MAX_CHARS:0]    end_mask,
    output logic                  q_rd,
    input  logic                  pop,
    output logic                  empty,
    output logic                  matched
);

    localparam int N = MAX_CHARS + 1;

    logic [N-1:0] active_reg;
    logic [N-1:0] pin;
    logic [N-1:0] set_cl;
    logic [N-1:0] adv;
    logic [N-1:0] adv_cl;
    logic [N-1:0] set_used;
    logic         hit;
    logic         go;
    logic         out_valid_reg;
    logic         matched_reg;

    // parallel prefix over runs of wildcards, log2 levels
    function automatic logic [N-1:0] close_set(input logic [N-1:0] s,
                                               input logic [N-1:0] p_in);
        logic [N-1:0] g;
        logic [N-1:0] p;
        g = s;
        p = p_in;
        for (int d = 1; d < N; d = d * 2)
        begin
            g = g | (p & (g << d));
            p = p & (p << d);
        end
        return g;
    endfunction

    // bit k can be reached from bit k-1 through a wildcard at k-1
    assign pin      = {prop_mask, 1'b0};
    assign set_cl   = close_set(active_reg, pin);
    assign adv      = {1'b0, set_cl[MAX_CHARS-1:0] & stay}
                    | {set_cl[MAX_CHARS-1:0] & step, 1'b0};
    assign adv_cl   = close_set(adv, pin);
    assign set_used = flags.has ? adv_cl : set_cl;
    assign hit      = |(set_used & end_mask);

    // a last item needs room in the result register
    assign go    = !q_empty && (!flags.last || !out_valid_reg || pop);
    assign q_rd  = go;
    assign empty = !out_valid_reg;
    assign matched = matched_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= N'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go && flags.last)
            begin
                active_reg <= N'(1);
            end
            else if (go && flags.has)
            begin
                active_reg <= adv_cl;
            end
            if (go && flags.last)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && flags.last)
        begin
            matched_reg <= hit;
        end
    end

    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        go && flags.last |=> out_valid_reg)
        else $error("finished name produced no result");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        go && flags.last |=> active_reg == N'(1))
        else $error("nfa not restarted after end of name");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop |-> !(go && flags.last))
        else $error("waiting result overwritten");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(active_reg))
        else $error("nfa state moved without an item");

endmodule

// ===== rtl/imap_wildcard_match.sv =====
// ---------------------------------------------------------------------------
// imap_wildcard_match
// Matches a streamed mailbox name against a list wildcard pattern.
// ---------------------------------------------------------------------------
// Usage: load the pattern with cfg_we/cfg_index/cfg_wdata (indexes 0-5 are
// the pattern words, 6 the length, 7 the hierarchy delimiter), then push the
// name one byte per item. '*' matches any run, '%' any run without the
// delimiter. The item with end_of_name set yields one matched result; an item
// with has_byte low and end_of_name set tests the empty name.
// Input side: push/full, taken when push is high and full is low. A new item
// is taken every cycle while full is low. Output side: empty/pop, result shown
// while empty is low, removed when pop is high.
// Path: a last item is written into a two-entry queue at its push edge, runs
// through the nfa once it is at the queue head and its result is registered
// in the result register, which lowers empty. Throughput is one item per
// cycle while no waiting result holds a last item at the queue head; the nfa
// update (advance plus two log-depth closures) is combinational.
// Reset: the queue and result are emptied, the nfa is at the start position,
// the pattern is empty and the delimiter is '/'.
// When pop is held low a waiting result stalls the next last item at the queue
// head and all items behind it; the queue then fills and full rises.
// ---------------------------------------------------------------------------
module imap_wildcard_match #(
    parameter int MAX_PATTERN_CHARS = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [imw_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               push,
    output logic                               full,
    input  logic [imw_pkg::CHAR_W-1:0]         name_byte,
    input  logic                               has_byte,
    input  logic                               end_of_name,
    output logic                               empty,
    input  logic                               pop,
    output logic                               matched
);

    localparam int M = MAX_PATTERN_CHARS;
    localparam int ENTRY_W = 2 * M + 2;

    logic                   q_full;
    logic                   q_wr;
    logic [ENTRY_W-1:0]     q_wdata;
    logic [ENTRY_W-1:0]     q_rdata;
    logic                   q_rd;
    logic                   q_empty;
    logic [M-1:0]           prop_mask;
    logic [M:0]             end_mask;
    imw_pkg::imw_flags_t    head_flags;

    imw_front #(
        .MAX_CHARS (M)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .name_byte   (name_byte),
        .has_byte    (has_byte),
        .end_of_name (end_of_name),
        .q_full      (q_full),
        .full        (full),
        .q_wr        (q_wr),
        .q_wdata     (q_wdata),
        .prop_mask   (prop_mask),
        .end_mask    (end_mask)
    );

    imw_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .q_full  (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .q_empty (q_empty)
    );

    assign head_flags = q_rdata[1:0];

    imw_back #(
        .MAX_CHARS (M)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .stay      (q_rdata[ENTRY_W-1 -: M]),
        .step      (q_rdata[M+1:2]),
        .flags     (head_flags),
        .prop_mask (prop_mask),
        .end_mask  (end_mask),
        .q_rd      (q_rd),
        .pop       (pop),
        .empty     (empty),
        .matched   (matched)
    );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the wildcard name matcher. A short table of
// hand-picked names and patterns runs first, then random patterns with names
// built mostly to follow them. Every result is checked in order against a fixed
// table value or a bench nfa model, with random gaps on both queue sides.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int MAX_CHARS      = 48;
    localparam int ITEM_TARGET    = 1200;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam logic [imw_pkg::CFG_IDX_W-1:0] CFG_PATTERN_WORD_FIRST = '0;

    typedef enum { ROW_ITEM, ROW_CFG } row_kind_t;
    typedef enum { EXP_MODEL, EXP_NO, EXP_YES } exp_kind_t;

    typedef struct {
        row_kind_t                       kind;
        logic [imw_pkg::CFG_IDX_W-1:0]   reg_index;
        logic [imw_pkg::CFG_DATA_W-1:0]  reg_data;
        logic [imw_pkg::CHAR_W-1:0]      ch;
        bit                              has;
        bit                              last;
        exp_kind_t                       want;
    } stim_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_we;
    logic [imw_pkg::CFG_IDX_W-1:0]    cfg_index;
    logic [imw_pkg::CFG_DATA_W-1:0]   cfg_wdata;
    logic                             push;
    logic                             full;
    logic [imw_pkg::CHAR_W-1:0]       name_byte;
    logic                             has_byte;
    logic                             end_of_name;
    logic                             empty;
    logic                             pop;
    logic                             matched;

    // bench copy of the configuration and the nfa
    logic [imw_pkg::CFG_DATA_W-1:0]   pattern_words [0:imw_pkg::WORD_COUNT-1];
    logic [imw_pkg::LEN_W-1:0]        pattern_len;
    logic [imw_pkg::CHAR_W-1:0]       delim_char;
    logic [MAX_CHARS:0]               nfa_state;

    bit                               match_expected [$];
    stim_row_t                        directed_rows [$];
    logic [imw_pkg::CHAR_W-1:0]       name_q [$];

    bit                      sender_burst;
    bit                      drain_fast;
    int                      mismatches;
    int                      items_sent;
    int                      names_checked;
    int                      settings_used;
    int                      quiet_cycles;

    imap_wildcard_match #(
        .MAX_PATTERN_CHARS(MAX_CHARS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .full       (full),
        .name_byte  (name_byte),
        .has_byte   (has_byte),
        .end_of_name(end_of_name),
        .empty      (empty),
        .pop        (pop),
        .matched    (matched)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [imw_pkg::CHAR_W-1:0] pattern_char(int i);
        return pattern_words[i / 8][8 * (i % 8) +: 8];
    endfunction

    function automatic int used_length();
        return (pattern_len > MAX_CHARS) ? MAX_CHARS : int'(pattern_len);
    endfunction

    function automatic bit is_wildcard(logic [imw_pkg::CHAR_W-1:0] c);
        return (c == imw_pkg::STAR_CHAR) || (c == imw_pkg::PERCENT_CHAR);
    endfunction

    // a wildcard may match the empty run, so it also enables the next position
    function automatic logic [MAX_CHARS:0] close_wildcards(logic [MAX_CHARS:0] set, int len);
        for (int i = 0; i < len; i++)
            if (set[i] && is_wildcard(pattern_char(i)))
                set[i + 1] = 1'b1;
        return set;
    endfunction

    function automatic logic [MAX_CHARS:0] consume_byte(logic [MAX_CHARS:0] set, int len,
                                                        logic [imw_pkg::CHAR_W-1:0] c);
        logic [MAX_CHARS:0]          next_set;
        logic [imw_pkg::CHAR_W-1:0]  p;
        next_set = '0;
        for (int i = 0; i < len; i++)
        begin
            if (set[i])
            begin
                p = pattern_char(i);
                if (p == imw_pkg::STAR_CHAR)
                    next_set[i] = 1'b1;
                else if (p == imw_pkg::PERCENT_CHAR)
                begin
                    if (c != delim_char)
                        next_set[i] = 1'b1;
                end
                else if (p == c)
                    next_set[i + 1] = 1'b1;
            end
        end
        return next_set;
    endfunction

    task automatic track_item(input logic [imw_pkg::CHAR_W-1:0] c, input bit has,
                              input bit last, output bit gives, output bit m);
        int                 len;
        logic [MAX_CHARS:0] set;
        len = used_length();
        set = close_wildcards(nfa_state, len);
        if (has)
        begin
            set = close_wildcards(consume_byte(set, len, c), len);
            nfa_state = set;
        end
        gives = last;
        m = set[len];
        if (last)
            nfa_state = (MAX_CHARS + 1)'(1);
    endtask

    function automatic logic [imw_pkg::CHAR_W-1:0] pick_char();
        case ($urandom_range(0, 5))
            0: return 8'h61;
            1: return 8'h62;
            2: return delim_char;
            3: return imw_pkg::STAR_CHAR;
            4: return imw_pkg::PERCENT_CHAR;
            default: return 8'($urandom());
        endcase
    endfunction

    function automatic stim_row_t item_row(logic [imw_pkg::CHAR_W-1:0] c, bit has, bit last,
                                           exp_kind_t want);
        stim_row_t row;
        row = '{ROW_ITEM, '0, '0, c, has, last, want};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(logic [imw_pkg::CFG_IDX_W-1:0] idx,
                                          logic [imw_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '{ROW_CFG, idx, data, '0, 1'b0, 1'b0, EXP_MODEL};
        return row;
    endfunction

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic send_item(logic [imw_pkg::CHAR_W-1:0] c, bit has, bit last,
                             exp_kind_t want);
        int gap;
        bit gives;
        bit m;
        gap = sender_burst ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push        <= 1'b1;
        name_byte   <= c;
        has_byte    <= has;
        end_of_name <= last;
        @(posedge clk);
        while (full) @(posedge clk);
        track_item(c, has, last, gives, m);
        if (gives)
            match_expected.push_back((want == EXP_MODEL) ? m : (want == EXP_YES));
        if (has || last)
            items_sent++;
    endtask

    // wait until every result is out, then let the pipeline settle
    task automatic quiesce();
        push <= 1'b0;
        while (match_expected.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [imw_pkg::CFG_IDX_W-1:0] idx,
                             logic [imw_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == imw_pkg::CFG_PATTERN_LENGTH)
            pattern_len = data[imw_pkg::LEN_W-1:0];
        else if (idx == imw_pkg::CFG_HIER_DELIM)
            delim_char = data[imw_pkg::CHAR_W-1:0];
        else
            pattern_words[idx] = data;
    endtask

    // result side
    initial
    begin : result_drain
        int stall;
        bit want;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = drain_fast ? 0 : $urandom_range(0, 14);
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
            names_checked++;
            if (match_expected.size() == 0)
                report_mismatch($sformatf("matched=%0d with no result expected", matched));
            else
            begin
                want = match_expected.pop_front();
                if (matched !== want)
                    report_mismatch($sformatf("matched=%0b, expected %0b", matched, want));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty) || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL imap_wildcard_match");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        int                             plen;
        int                             n_names;
        int                             pick;
        bit                             tail_empty;
        bit                             in_cfg;
        logic [imw_pkg::CFG_DATA_W-1:0] w;
        logic [imw_pkg::CFG_DATA_W-1:0] d;
        logic [imw_pkg::CHAR_W-1:0]     c;
        logic [imw_pkg::CHAR_W-1:0]     f;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_wdata   = '0;
        push        = 1'b0;
        name_byte   = '0;
        has_byte    = 1'b0;
        end_of_name = 1'b0;
        sender_burst = 1'b0;
        drain_fast   = 1'b0;
        mismatches = 0;
        items_sent = 0;
        names_checked = 0;
        settings_used = 0;
        for (int k = 0; k < imw_pkg::WORD_COUNT; k++)
            pattern_words[k] = '0;
        pattern_len = '0;
        delim_char  = imw_pkg::DELIM_RESET;
        nfa_state   = (MAX_CHARS + 1)'(1);

        // empty pattern straight after reset
        directed_rows.push_back(item_row(8'h00, 1'b0, 1'b1, EXP_YES));
        directed_rows.push_back(item_row(8'hFF, 1'b1, 1'b1, EXP_NO));
        // lone star, with a byteless item inside the name
        directed_rows.push_back(cfg_row(CFG_PATTERN_WORD_FIRST, 64'(imw_pkg::STAR_CHAR)));
        directed_rows.push_back(cfg_row(imw_pkg::CFG_PATTERN_LENGTH, 64'd1));
        directed_rows.push_back(item_row(8'h00, 1'b0, 1'b1, EXP_YES));
        directed_rows.push_back(item_row(8'hFF, 1'b1, 1'b0, EXP_MODEL));
        directed_rows.push_back(item_row(8'h00, 1'b0, 1'b0, EXP_MODEL));
        directed_rows.push_back(item_row(8'h2F, 1'b1, 1'b1, EXP_YES));
        // percent must not cross the reset delimiter
        directed_rows.push_back(cfg_row(CFG_PATTERN_WORD_FIRST, 64'(imw_pkg::PERCENT_CHAR)));
        directed_rows.push_back(item_row(8'h2F, 1'b1, 1'b1, EXP_NO));
        directed_rows.push_back(item_row(8'h41, 1'b1, 1'b1, EXP_YES));
        directed_rows.push_back(cfg_row(imw_pkg::CFG_HIER_DELIM, 64'h0));
        directed_rows.push_back(item_row(8'h00, 1'b1, 1'b1, EXP_NO));
        directed_rows.push_back(item_row(8'h2F, 1'b1, 1'b1, EXP_YES));
        // zero byte as a literal pattern character
        directed_rows.push_back(cfg_row(imw_pkg::CFG_HIER_DELIM, 64'hFF));
        directed_rows.push_back(cfg_row(CFG_PATTERN_WORD_FIRST, 64'h0));
        directed_rows.push_back(item_row(8'h00, 1'b1, 1'b1, EXP_YES));
        directed_rows.push_back(item_row(8'h01, 1'b1, 1'b1, EXP_NO));
        // pattern rewritten halfway through a name keeps the reached position
        directed_rows.push_back(cfg_row(CFG_PATTERN_WORD_FIRST, 64'h6261));
        directed_rows.push_back(cfg_row(imw_pkg::CFG_PATTERN_LENGTH, 64'd2));
        directed_rows.push_back(item_row(8'h61, 1'b1, 1'b0, EXP_MODEL));
        directed_rows.push_back(cfg_row(CFG_PATTERN_WORD_FIRST, 64'h6278));
        directed_rows.push_back(item_row(8'h62, 1'b1, 1'b1, EXP_YES));
        // full pattern of stars, length beyond the limit and at the limit
        for (int k = 0; k < imw_pkg::WORD_COUNT; k++)
            directed_rows.push_back(cfg_row(CFG_PATTERN_WORD_FIRST
                                            + imw_pkg::CFG_IDX_W'(k),
                                            {8{imw_pkg::STAR_CHAR}}));
        directed_rows.push_back(cfg_row(imw_pkg::CFG_PATTERN_LENGTH, 64'd63));
        directed_rows.push_back(item_row(8'h80, 1'b1, 1'b1, EXP_YES));
        directed_rows.push_back(cfg_row(imw_pkg::CFG_PATTERN_LENGTH, 64'd48));
        directed_rows.push_back(item_row(8'h00, 1'b0, 1'b1, EXP_YES));
        // mixed pattern "a%/*b"
        directed_rows.push_back(cfg_row(imw_pkg::CFG_HIER_DELIM, 64'h2F));
        directed_rows.push_back(cfg_row(CFG_PATTERN_WORD_FIRST, 64'h622A2F2561));
        directed_rows.push_back(cfg_row(imw_pkg::CFG_PATTERN_LENGTH, 64'd5));
        directed_rows.push_back(item_row(8'h61, 1'b1, 1'b0, EXP_MODEL));
        directed_rows.push_back(item_row(8'h78, 1'b1, 1'b0, EXP_MODEL));
        directed_rows.push_back(item_row(8'h2F, 1'b1, 1'b0, EXP_MODEL));
        directed_rows.push_back(item_row(8'h79, 1'b1, 1'b0, EXP_MODEL));
        directed_rows.push_back(item_row(8'h2F, 1'b1, 1'b0, EXP_MODEL));
        directed_rows.push_back(item_row(8'h62, 1'b1, 1'b1, EXP_MODEL));
        directed_rows.push_back(item_row(8'h61, 1'b1, 1'b0, EXP_MODEL));
        directed_rows.push_back(item_row(8'h2F, 1'b1, 1'b1, EXP_MODEL));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        in_cfg = 1'b0;
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CFG)
            begin
                if (!in_cfg)
                begin
                    quiesce();
                    settings_used++;
                end
                write_reg(directed_rows[r].reg_index, directed_rows[r].reg_data);
                in_cfg = 1'b1;
            end
            else
            begin
                send_item(directed_rows[r].ch, directed_rows[r].has, directed_rows[r].last,
                          directed_rows[r].want);
                in_cfg = 1'b0;
            end
        end

        while (items_sent < ITEM_TARGET)
        begin
            quiesce();
            settings_used++;
            sender_burst = ($urandom_range(0, 3) == 0);
            drain_fast   = ($urandom_range(0, 3) == 0);

            pick = $urandom_range(0, 19);
            if (pick == 0)
                plen = 0;
            else if (pick == 1)
                plen = MAX_CHARS;
            else if (pick == 2)
                plen = $urandom_range(MAX_CHARS + 1, 63);
            else
                plen = $urandom_range(1, 8);

            d = {$urandom(), $urandom()};
            case ($urandom_range(0, 7))
                0: d[imw_pkg::CHAR_W-1:0] = 8'h00;
                1: d[imw_pkg::CHAR_W-1:0] = 8'hFF;
                2: d[imw_pkg::CHAR_W-1:0] = 8'h2E;
                3: d[imw_pkg::CHAR_W-1:0] = 8'($urandom());
                default: d[imw_pkg::CHAR_W-1:0] = imw_pkg::DELIM_RESET;
            endcase
            write_reg(imw_pkg::CFG_HIER_DELIM, d);

            // unused pattern bytes keep random content
            for (int k = 0; k < imw_pkg::WORD_COUNT; k++)
            begin
                w = {$urandom(), $urandom()};
                for (int j = 0; j < 8; j++)
                    if (8 * k + j < plen)
                        w[8 * j +: 8] = pick_char();
                write_reg(CFG_PATTERN_WORD_FIRST + imw_pkg::CFG_IDX_W'(k), w);
            end
            d = {$urandom(), $urandom()};
            d[imw_pkg::LEN_W-1:0] = imw_pkg::LEN_W'(plen);
            write_reg(imw_pkg::CFG_PATTERN_LENGTH, d);

            n_names = $urandom_range(2, 8);
            repeat (n_names)
            begin
                name_q.delete();
                if ($urandom_range(0, 9) == 0)
                begin
                    repeat ($urandom_range(0, 6)) name_q.push_back(8'($urandom()));
                end
                else
                begin
                    // mostly a name that follows the pattern, with rare flaws
                    for (int i = 0; i < used_length(); i++)
                    begin
                        c = pattern_char(i);
                        if (c == imw_pkg::STAR_CHAR)
                            repeat ($urandom_range(0, 3)) name_q.push_back(pick_char());
                        else if (c == imw_pkg::PERCENT_CHAR)
                        begin
                            repeat ($urandom_range(0, 3))
                            begin
                                f = pick_char();
                                if (f == delim_char && $urandom_range(0, 7) != 0)
                                    f = f ^ 8'h01;
                                name_q.push_back(f);
                            end
                        end
                        else
                            name_q.push_back(($urandom_range(0, 15) == 0) ? pick_char() : c);
                    end
                end

                tail_empty = ($urandom_range(0, 9) == 0) || (name_q.size() == 0);
                foreach (name_q[j])
                begin
                    if ($urandom_range(0, 19) == 0)
                        send_item(8'($urandom()), 1'b0, 1'b0, EXP_MODEL);
                    send_item(name_q[j], 1'b1, !tail_empty && (j == name_q.size() - 1),
                              EXP_MODEL);
                end
                if (tail_empty)
                    send_item(8'($urandom()), 1'b0, 1'b1, EXP_MODEL);
            end

            // leave a name open so the next pattern picks it up halfway
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_item(pick_char(), 1'b1, 1'b0, EXP_MODEL);
        end

        quiesce();
        repeat (6) @(posedge clk);

        $display("covered %0d items and %0d names under %0d pattern settings",
                 items_sent, names_checked, settings_used);
        if (mismatches == 0)
            $display("PASS imap_wildcard_match");
        else
            $display("FAIL imap_wildcard_match");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/imw_pkg.sv
rtl/imw_queue.sv
rtl/imw_front.sv
rtl/imw_back.sv
rtl/imap_wildcard_match.sv
tb/tb_top.sv
